>>> src/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, codes and character tests for the source character classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	typedef enum logic [3:0] {
		MD_LINE_START = 4'd0,
		MD_IDLE       = 4'd1,
		MD_PAREN      = 4'd2,
		MD_DASH       = 4'd3,
		MD_WORD       = 4'd4,
		MD_NUM_INT    = 4'd5,
		MD_NUM_DOT    = 4'd6,
		MD_NUM_FRAC   = 4'd7,
		MD_NUM_EXP    = 4'd8,
		MD_NUM_EXPDIG = 4'd9,
		MD_STRING     = 4'd10,
		MD_CMT        = 4'd11,
		MD_CMT_CARRY  = 4'd12,
		MD_DASH_LINE  = 4'd13
	} mode_t;

	typedef enum logic [2:0] {
		CL_NORMAL  = 3'd0,
		CL_KEYWORD = 3'd1,
		CL_IDENT   = 3'd2,
		CL_NUMBER  = 3'd3,
		CL_STRING  = 3'd4,
		CL_COMMENT = 3'd5,
		CL_INVALID = 3'd6
	} class_t;

	localparam int RUN_W       = 13;
	localparam int MAX_RES     = 4;
	localparam int QUEUE_DEPTH = 4;

	// number flag bits
	localparam int NF_LETTERS = 0;
	localparam int NF_OCT     = 1;
	localparam int NF_HEX     = 2;
	localparam logic [2:0] NF_INIT = 3'b110;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_UP_E   = 8'h45;

	typedef struct packed {
		class_t             cls;
		logic [RUN_W-1:0]   len;
	} run_t;

	// one queue entry: the runs caused by one character, cnt is 1..4
	typedef struct packed {
		run_t [MAX_RES-1:0] runs;
		logic [2:0]         cnt;
	} entry_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h37;
	endfunction

	function automatic logic is_hexd(input logic [7:0] c);
		return is_dig(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic is_sym(input logic [7:0] c);
		return c inside {8'h3A, 8'h2C, 8'h2E, 8'h3D, 8'h3B, 8'h28, 8'h29, 8'h5B,
			8'h5D, 8'h7B, 8'h7D, 8'h7C, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h26, 8'h3C,
			8'h3E, 8'h23, 8'h5E, 8'h40};
	endfunction

	// class of a number that holds letters, decided by its last character
	function automatic class_t letter_num_class(input logic [7:0] last_c,
		input logic oct_ok, input logic hex_ok);
		class_t r;
		case (last_c)
			8'h43: r = oct_ok ? CL_STRING : CL_INVALID;
			8'h42: r = oct_ok ? CL_NUMBER : CL_INVALID;
			8'h78, 8'h58: r = hex_ok ? CL_STRING : CL_INVALID;
			8'h68, 8'h48: r = hex_ok ? CL_NUMBER : CL_INVALID;
			default: r = CL_INVALID;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/scc_kw_store.sv
// ----------------------------------------------------------------------------
// scc_kw_store
// Keyword character memory, one row per position, one byte lane per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_kw_store #(
	parameter int KEYWORD_COUNT   = 64,
	parameter int KEYWORD_MAX_LEN = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         wr_en,
	input  wire logic [$clog2(KEYWORD_MAX_LEN)-1:0]           wr_row,
	input  wire logic [((KEYWORD_COUNT > 1) ? $clog2(KEYWORD_COUNT) : 1)-1:0] wr_slot,
	input  wire logic [7:0]                                   wr_data,
	input  wire logic [$clog2(KEYWORD_MAX_LEN)-1:0]           rd_row,
	output logic      [KEYWORD_COUNT*8-1:0]                   rd_data
);

	localparam int PW = $clog2(KEYWORD_MAX_LEN);
	localparam int SW = (KEYWORD_COUNT > 1) ? $clog2(KEYWORD_COUNT) : 1;

	logic [KEYWORD_COUNT*8-1:0] kw_mem [KEYWORD_MAX_LEN];
	logic [KEYWORD_COUNT*8-1:0] rd_q;
	logic                       fwd_q;
	logic [SW-1:0]              fwd_slot_q;
	logic [7:0]                 fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			kw_mem[wr_row][wr_slot*8 +: 8] <= wr_data;
		end
		rd_q       <= kw_mem[rd_row];
		fwd_slot_q <= wr_slot;
		fwd_data_q <= wr_data;
	end

	// a write to the row being read is forwarded, so it shows in the read data of the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= wr_en && (wr_row == rd_row);
		end
	end

	always_comb begin
		rd_data = rd_q;
		if (fwd_q) begin
			rd_data[fwd_slot_q*8 +: 8] = fwd_data_q;
		end
	end

	logic unused_pw;
	assign unused_pw = (PW > 0);

endmodule

`default_nettype wire

>>> src/scc_front.sv
// ----------------------------------------------------------------------------
// scc_front
// Lexer front end: one character per cycle while acc is high, forms class runs for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_front #(
	parameter int KEYWORD_COUNT   = 64,
	parameter int KEYWORD_MAX_LEN = 16,
	parameter int LINE_MAX        = 4096
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 dash_on,
	input  wire logic                                 acc,
	input  wire logic                                 action,
	input  wire logic [7:0]                           char_code,
	input  wire logic                                 line_end,
	input  wire logic [15:0]                          start_depth,
	input  wire logic [5:0]                           keyword_slot,
	input  wire logic [3:0]                           keyword_pos,
	input  wire logic [4:0]                           keyword_len,
	output logic                                      kw_wr_en,
	output logic [$clog2(KEYWORD_MAX_LEN)-1:0]        kw_wr_row,
	output logic [((KEYWORD_COUNT > 1) ? $clog2(KEYWORD_COUNT) : 1)-1:0] kw_wr_slot,
	output logic [$clog2(KEYWORD_MAX_LEN)-1:0]        kw_rd_row,
	input  wire logic [KEYWORD_COUNT*8-1:0]           kw_rd_data,
	output logic                                      enq_valid,
	output scc_pkg::entry_t                           enq_entry
);

	localparam int LW = $clog2(LINE_MAX + 1);
	localparam int PW = $clog2(KEYWORD_MAX_LEN);
	localparam int SW = (KEYWORD_COUNT > 1) ? $clog2(KEYWORD_COUNT) : 1;

	scc_pkg::mode_t            mode_q, mode_a, mode_c;
	logic [15:0]               depth_q, depth_a;
	logic [LW-1:0]             rc_q, rc_a, rc_c;
	logic [7:0]                held_q, held_a, held_c;
	logic [7:0]                quote_q, quote_a;
	logic [2:0]                flags_q, flags_a, flags_c;
	scc_pkg::class_t           ocls_q, ocls_c;
	logic [LW-1:0]             olen_q, olen_s, olen_c;
	logic [LW-1:0]             lpos_q, lpos_s, lpos_c, lpos_n;
	logic [KEYWORD_COUNT-1:0]  match_q, match_a, match_cont, match_init;
	logic [4:0]                klen_q [KEYWORD_COUNT];
	logic                      kw_hit_q, kw_hit_a;
	logic                      st, fin;
	logic [3:0]                e_v;
	scc_pkg::class_t           e_c [4];
	logic [LW-1:0]             e_n [4];
	logic [2:0]                nres;
	scc_pkg::entry_t           res;
	logic                      chr_acc;
	scc_pkg::mode_t            mode_nx;
	logic [LW-1:0]             rc_nx;

	assign chr_acc = acc && action;

	always_comb begin
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			match_init[k] = (kw_rd_data[k*8 +: 8] == char_code);
			match_cont[k] = match_q[k] && (32'(rc_q) < KEYWORD_MAX_LEN) && match_init[k];
		end
	end

	always_comb begin
		kw_hit_q = 1'b0;
		kw_hit_a = 1'b0;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			if (match_q[k] && 32'(klen_q[k]) == 32'(rc_q)) kw_hit_q = 1'b1;
			if (match_a[k] && 32'(klen_q[k]) == 32'(rc_a)) kw_hit_a = 1'b1;
		end
	end

	// character step
	always_comb begin
		mode_a  = mode_q;
		depth_a = depth_q;
		rc_a    = rc_q;
		held_a  = held_q;
		quote_a = quote_q;
		flags_a = flags_q;
		match_a = match_q;
		olen_s  = olen_q;
		lpos_s  = lpos_q;
		st      = 1'b0;
		e_v     = '0;
		for (int i = 0; i < 4; i++) begin
			e_c[i] = scc_pkg::CL_NORMAL;
			e_n[i] = '0;
		end
		if (mode_q == scc_pkg::MD_LINE_START) begin
			depth_a = start_depth;
			mode_a  = (start_depth != 16'd0) ? scc_pkg::MD_CMT_CARRY : scc_pkg::MD_IDLE;
			held_a  = '0;
			olen_s  = '0;
			lpos_s  = '0;
		end
		case (mode_a)
			scc_pkg::MD_PAREN: begin
				if (char_code == scc_pkg::CH_STAR) begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_COMMENT; e_n[0] = LW'(2);
					mode_a  = scc_pkg::MD_CMT;
					depth_a = 16'd1;
					held_a  = '0;
				end else begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_NORMAL; e_n[0] = LW'(1);
					st = 1'b1;
				end
			end
			scc_pkg::MD_DASH: begin
				if (char_code == scc_pkg::CH_DASH) begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_COMMENT; e_n[0] = LW'(2);
					mode_a = scc_pkg::MD_DASH_LINE;
				end else begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_NORMAL; e_n[0] = LW'(1);
					st = 1'b1;
				end
			end
			scc_pkg::MD_WORD: begin
				if (scc_pkg::is_letter(char_code) || scc_pkg::is_dig(char_code)) begin
					match_a = match_cont;
					rc_a    = rc_q + LW'(1);
				end else begin
					e_v[0] = 1'b1;
					e_c[0] = kw_hit_q ? scc_pkg::CL_KEYWORD : scc_pkg::CL_IDENT;
					e_n[0] = rc_q;
					st = 1'b1;
				end
			end
			scc_pkg::MD_NUM_INT: begin
				if (scc_pkg::is_letter(char_code) || scc_pkg::is_dig(char_code)) begin
					if (!scc_pkg::is_oct(held_q)) flags_a[scc_pkg::NF_OCT] = 1'b0;
					if (!scc_pkg::is_hexd(held_q)) flags_a[scc_pkg::NF_HEX] = 1'b0;
					if (scc_pkg::is_letter(char_code)) flags_a[scc_pkg::NF_LETTERS] = 1'b1;
					held_a = char_code;
					rc_a   = rc_q + LW'(1);
				end else if (flags_q[scc_pkg::NF_LETTERS]) begin
					e_v[0] = 1'b1;
					e_c[0] = scc_pkg::letter_num_class(held_q, flags_q[scc_pkg::NF_OCT],
						flags_q[scc_pkg::NF_HEX]);
					e_n[0] = rc_q;
					st = 1'b1;
				end else if (char_code == scc_pkg::CH_DOT) begin
					mode_a = scc_pkg::MD_NUM_DOT;
				end else begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_NUMBER; e_n[0] = rc_q;
					st = 1'b1;
				end
			end
			scc_pkg::MD_NUM_DOT: begin
				if (char_code == scc_pkg::CH_DOT) begin
					// range dot: the held dot is a symbol, not a fraction
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_NUMBER; e_n[0] = rc_q;
					e_v[1] = 1'b1; e_c[1] = scc_pkg::CL_NORMAL; e_n[1] = LW'(1);
					st = 1'b1;
				end else if (scc_pkg::is_dig(char_code)) begin
					rc_a   = rc_q + LW'(2);
					mode_a = scc_pkg::MD_NUM_FRAC;
				end else if (char_code == scc_pkg::CH_UP_E) begin
					rc_a   = rc_q + LW'(2);
					mode_a = scc_pkg::MD_NUM_EXP;
				end else begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_NUMBER; e_n[0] = rc_q + LW'(1);
					st = 1'b1;
				end
			end
			scc_pkg::MD_NUM_FRAC: begin
				if (scc_pkg::is_dig(char_code)) begin
					rc_a = rc_q + LW'(1);
				end else if (char_code == scc_pkg::CH_UP_E) begin
					rc_a   = rc_q + LW'(1);
					mode_a = scc_pkg::MD_NUM_EXP;
				end else begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_NUMBER; e_n[0] = rc_q;
					st = 1'b1;
				end
			end
			scc_pkg::MD_NUM_EXP: begin
				if (char_code == scc_pkg::CH_PLUS || char_code == scc_pkg::CH_DASH ||
					scc_pkg::is_dig(char_code)) begin
					rc_a   = rc_q + LW'(1);
					mode_a = scc_pkg::MD_NUM_EXPDIG;
				end else begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_NUMBER; e_n[0] = rc_q;
					st = 1'b1;
				end
			end
			scc_pkg::MD_NUM_EXPDIG: begin
				if (scc_pkg::is_dig(char_code)) begin
					rc_a = rc_q + LW'(1);
				end else begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_NUMBER; e_n[0] = rc_q;
					st = 1'b1;
				end
			end
			scc_pkg::MD_STRING: begin
				rc_a = rc_q + LW'(1);
				if (char_code == quote_q) begin
					e_v[0] = 1'b1; e_c[0] = scc_pkg::CL_STRING; e_n[0] = rc_q + LW'(1);
					mode_a = scc_pkg::MD_IDLE;
				end
			end
			scc_pkg::MD_CMT, scc_pkg::MD_CMT_CARRY: begin
				e_v[2] = 1'b1; e_c[2] = scc_pkg::CL_COMMENT; e_n[2] = LW'(1);
				if (held_a == scc_pkg::CH_LPAREN && char_code == scc_pkg::CH_STAR) begin
					if (depth_a != 16'hFFFF) depth_a = depth_a + 16'd1;
					held_a = '0;
				end else if (held_a == scc_pkg::CH_STAR && char_code == scc_pkg::CH_RPAREN) begin
					depth_a = depth_a - 16'd1;
					held_a  = '0;
					if (depth_a == 16'd0) mode_a = scc_pkg::MD_IDLE;
				end else if (mode_a == scc_pkg::MD_CMT_CARRY && dash_on &&
					held_a == scc_pkg::CH_DASH && char_code == scc_pkg::CH_DASH) begin
					mode_a = scc_pkg::MD_DASH_LINE;
					held_a = '0;
				end else if (char_code == scc_pkg::CH_LPAREN || char_code == scc_pkg::CH_STAR ||
					char_code == scc_pkg::CH_DASH) begin
					held_a = char_code;
				end else begin
					held_a = '0;
				end
			end
			scc_pkg::MD_DASH_LINE: begin
				e_v[2] = 1'b1; e_c[2] = scc_pkg::CL_COMMENT; e_n[2] = LW'(1);
			end
			default: begin
				st = 1'b1;
			end
		endcase
		if (st) begin
			mode_a = scc_pkg::MD_IDLE;
			if (scc_pkg::is_letter(char_code)) begin
				match_a = match_init;
				rc_a    = LW'(1);
				mode_a  = scc_pkg::MD_WORD;
			end else if (scc_pkg::is_dig(char_code)) begin
				rc_a    = LW'(1);
				held_a  = char_code;
				flags_a = scc_pkg::NF_INIT;
				mode_a  = scc_pkg::MD_NUM_INT;
			end else if (char_code == scc_pkg::CH_SQUOTE || char_code == scc_pkg::CH_DQUOTE) begin
				quote_a = char_code;
				rc_a    = LW'(1);
				mode_a  = scc_pkg::MD_STRING;
			end else if (char_code == scc_pkg::CH_LPAREN) begin
				mode_a = scc_pkg::MD_PAREN;
			end else if (char_code == scc_pkg::CH_DASH && dash_on) begin
				mode_a = scc_pkg::MD_DASH;
			end else begin
				e_v[2] = 1'b1;
				e_c[2] = scc_pkg::is_sym(char_code) ? scc_pkg::CL_NORMAL : scc_pkg::CL_INVALID;
				e_n[2] = LW'(1);
			end
		end
	end

	// line end or line length limit flush, and run merging
	always_comb begin
		lpos_n = lpos_s + LW'(1);
		fin    = line_end || (32'(lpos_n) >= LINE_MAX);
		e_v[3] = 1'b0;
		e_c[3] = scc_pkg::CL_NORMAL;
		e_n[3] = '0;
		if (fin) begin
			case (mode_a)
				scc_pkg::MD_PAREN, scc_pkg::MD_DASH: begin
					e_v[3] = 1'b1; e_c[3] = scc_pkg::CL_NORMAL; e_n[3] = LW'(1);
				end
				scc_pkg::MD_WORD: begin
					e_v[3] = 1'b1;
					e_c[3] = kw_hit_a ? scc_pkg::CL_KEYWORD : scc_pkg::CL_IDENT;
					e_n[3] = rc_a;
				end
				scc_pkg::MD_NUM_INT: begin
					e_v[3] = 1'b1;
					e_c[3] = flags_a[scc_pkg::NF_LETTERS] ?
						scc_pkg::letter_num_class(held_a, flags_a[scc_pkg::NF_OCT],
							flags_a[scc_pkg::NF_HEX]) : scc_pkg::CL_NUMBER;
					e_n[3] = rc_a;
				end
				scc_pkg::MD_NUM_DOT: begin
					e_v[3] = 1'b1; e_c[3] = scc_pkg::CL_NUMBER; e_n[3] = rc_a + LW'(1);
				end
				scc_pkg::MD_NUM_FRAC, scc_pkg::MD_NUM_EXP, scc_pkg::MD_NUM_EXPDIG: begin
					e_v[3] = 1'b1; e_c[3] = scc_pkg::CL_NUMBER; e_n[3] = rc_a;
				end
				scc_pkg::MD_STRING: begin
					e_v[3] = 1'b1; e_c[3] = scc_pkg::CL_INVALID; e_n[3] = rc_a;
				end
				default: begin
					e_v[3] = 1'b0;
				end
			endcase
		end
		ocls_c = ocls_q;
		olen_c = olen_s;
		nres   = '0;
		res    = '0;
		for (int i = 0; i < 4; i++) begin
			if (e_v[i] && e_n[i] != '0) begin
				if (olen_c != '0 && ocls_c != e_c[i]) begin
					if (nres < 3'(scc_pkg::MAX_RES)) begin
						res.runs[nres[1:0]].cls = ocls_c;
						res.runs[nres[1:0]].len = scc_pkg::RUN_W'(olen_c);
						nres = nres + 3'd1;
					end
					olen_c = '0;
				end
				ocls_c = e_c[i];
				olen_c = olen_c + e_n[i];
			end
		end
		if (fin && olen_c != '0) begin
			if (nres < 3'(scc_pkg::MAX_RES)) begin
				res.runs[nres[1:0]].cls = ocls_c;
				res.runs[nres[1:0]].len = scc_pkg::RUN_W'(olen_c);
				nres = nres + 3'd1;
			end
			olen_c = '0;
		end
		res.cnt = nres;
		mode_c  = fin ? scc_pkg::MD_LINE_START : mode_a;
		rc_c    = fin ? '0 : rc_a;
		held_c  = fin ? '0 : held_a;
		flags_c = fin ? '0 : flags_a;
		lpos_c  = fin ? '0 : lpos_n;
	end

	assign enq_valid = chr_acc && (nres != 3'd0);
	assign enq_entry = res;

	// store writes
	assign kw_wr_en   = acc && !action && (32'(keyword_slot) < KEYWORD_COUNT) &&
		(32'(keyword_pos) < KEYWORD_MAX_LEN);
	assign kw_wr_row  = PW'(keyword_pos);
	assign kw_wr_slot = SW'(keyword_slot);

	// row for the next character: its word position, or row 0 for a new token
	assign mode_nx   = chr_acc ? mode_c : mode_q;
	assign rc_nx     = chr_acc ? rc_c : rc_q;
	assign kw_rd_row = (mode_nx == scc_pkg::MD_WORD && 32'(rc_nx) < KEYWORD_MAX_LEN) ?
		PW'(rc_nx) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= scc_pkg::MD_LINE_START;
			depth_q <= '0;
			rc_q    <= '0;
			held_q  <= '0;
			quote_q <= '0;
			flags_q <= '0;
			ocls_q  <= scc_pkg::CL_NORMAL;
			olen_q  <= '0;
			lpos_q  <= '0;
			match_q <= '0;
			for (int k = 0; k < KEYWORD_COUNT; k++) klen_q[k] <= '0;
		end else if (chr_acc) begin
			mode_q  <= mode_c;
			depth_q <= depth_a;
			rc_q    <= rc_c;
			held_q  <= held_c;
			quote_q <= quote_a;
			flags_q <= flags_c;
			ocls_q  <= ocls_c;
			olen_q  <= olen_c;
			lpos_q  <= lpos_c;
			match_q <= match_a;
		end else if (acc && (32'(keyword_slot) < KEYWORD_COUNT)) begin
			klen_q[SW'(keyword_slot)] <= keyword_len;
		end
	end

endmodule

`default_nettype wire

>>> src/scc_queue.sv
// ----------------------------------------------------------------------------
// scc_queue
// Short FIFO of run groups between the lexer and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  scc_pkg::entry_t       push_data,
	input  wire logic             pop,
	output scc_pkg::entry_t       head,
	output logic                  not_empty,
	output logic                  full
);

	localparam int AW = $clog2(scc_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(scc_pkg::QUEUE_DEPTH + 1);

	scc_pkg::entry_t mem_q [scc_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(scc_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

>>> src/scc_back.sv
// ----------------------------------------------------------------------------
// scc_back
// Output side: sends the runs of the head queue entry one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  scc_pkg::entry_t   head,
	input  wire logic         head_valid,
	output logic              pop,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,
	output logic              m_tlast
);

	logic [1:0]    idx_q;
	scc_pkg::run_t cur;

	assign cur      = head.runs[idx_q];
	assign m_tvalid = head_valid;
	assign m_tdata  = {cur.len, cur.cls};
	assign m_tlast  = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign pop      = m_tvalid && m_tready && m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= m_tlast ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

>>> src/source_char_classifier.sv
// ----------------------------------------------------------------------------
// source_char_classifier
// Line-oriented lexer for Modula-2 style source, returns class runs.
// ----------------------------------------------------------------------------
//
// channel   dir  tdata / tuser / tlast
// s_*       in   tdata: char_code, start_depth, keyword_slot, keyword_pos,
//                keyword_len; tuser: action; tlast: line_end
// m_*       out  tdata: char_class, run_length; tlast: last
// cfg_*     in   cfg_wdata: dash_comments_on, written while cfg_we is high
//
// One character or store write is taken per cycle while s_tready is high;
// the lexer state, keyword match vector and keyword row read advance in that cycle.
// Each character yields 0..4 runs that go into a 4-entry queue; the output
// side sends one run per cycle while m_tready is high, and each run of a
// character is its own transfer. s_tready drops only when the queue is full.
// Reset clears the lexer, match vector and keyword lengths at once; keyword
// characters hold whatever was written.
// ----------------------------------------------------------------------------
`default_nettype none

module source_char_classifier #(
	parameter int KEYWORD_COUNT   = 64,
	parameter int KEYWORD_MAX_LEN = 16,
	parameter int LINE_MAX        = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,   // dash_comments_on
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] char_code, [23:8] start_depth, [29:24] keyword_slot,
	// [33:30] keyword_pos, [38:34] keyword_len, [39] zero
	input  wire logic [39:0] s_tdata,
	input  wire logic        s_tuser,     // action
	input  wire logic        s_tlast,     // line_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,     // [2:0] char_class, [15:3] run_length
	output logic             m_tlast      // last
);

	localparam int PW = $clog2(KEYWORD_MAX_LEN);
	localparam int SW = (KEYWORD_COUNT > 1) ? $clog2(KEYWORD_COUNT) : 1;

	logic                       dash_q;
	logic                       acc;
	logic                       kw_wr_en;
	logic [PW-1:0]              kw_wr_row, kw_rd_row;
	logic [SW-1:0]              kw_wr_slot;
	logic [KEYWORD_COUNT*8-1:0] kw_rd_data;
	logic                       enq_valid;
	scc_pkg::entry_t            enq_entry, head;
	logic                       q_not_empty, q_full, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_q <= 1'b1;
		end else if (cfg_we) begin
			dash_q <= cfg_wdata;
		end
	end

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	scc_kw_store #(
		.KEYWORD_COUNT  (KEYWORD_COUNT),
		.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (kw_wr_en),
		.wr_row  (kw_wr_row),
		.wr_slot (kw_wr_slot),
		.wr_data (s_tdata[7:0]),
		.rd_row  (kw_rd_row),
		.rd_data (kw_rd_data)
	);

	scc_front #(
		.KEYWORD_COUNT  (KEYWORD_COUNT),
		.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
		.LINE_MAX       (LINE_MAX)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.dash_on     (dash_q),
		.acc         (acc),
		.action      (s_tuser),
		.char_code   (s_tdata[7:0]),
		.line_end    (s_tlast),
		.start_depth (s_tdata[23:8]),
		.keyword_slot(s_tdata[29:24]),
		.keyword_pos (s_tdata[33:30]),
		.keyword_len (s_tdata[38:34]),
		.kw_wr_en    (kw_wr_en),
		.kw_wr_row   (kw_wr_row),
		.kw_wr_slot  (kw_wr_slot),
		.kw_rd_row   (kw_rd_row),
		.kw_rd_data  (kw_rd_data),
		.enq_valid   (enq_valid),
		.enq_entry   (enq_entry)
	);

	scc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (enq_valid),
		.push_data(enq_entry),
		.pop      (pop),
		.head     (head),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	scc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(q_not_empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// a store write never produces runs
	a_store_no_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !s_tuser) |-> !enq_valid)
		else $error("store write produced runs");

	// queued groups always hold one to four runs
	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		enq_valid |-> (enq_entry.cnt != 3'd0 && enq_entry.cnt <= 3'd4))
		else $error("bad run count on enqueue");

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !enq_valid)
		else $error("push into full queue");

endmodule

`default_nettype wire
